FILE: rtl/core/assert_macros.svh
// Assertion macros for the port-level checker.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Types, codes and constants of the shift register ROM reader.
// ----------------------------------------------------------------------------
package srr_pkg;

    // Field widths of the channels
    localparam int KIND_W       = 2;
    localparam int ADDR_FIELD_W = 24;
    localparam int BYTE_W       = 8;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int TICK_W       = 8;

    // Default sizes of the address chain and the data register
    localparam int SRR_ADDR_BITS = 24;
    localparam int SRR_DATA_BITS = 8;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HALF_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SER_SETUP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HALF_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SETUP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME     = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READ_DONE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PASS      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAIL      = 3'd4;

    // Sequencer phases; every phase from RD_SER on is busy
    typedef enum logic [4:0] {
        PH_IDLE, PH_RDONE, PH_PASS, PH_FAIL,
        RD_SER, RD_CKH, RD_CKL, RD_LTH, RD_LTL, RD_EN, RD_LDH, RD_LDL, RD_MODE,
        RD_SMP, RD_SCL, RD_DIS, RD_END,
        CK_ACLR, CK_AREL, CK_IREL, CK_FL, CK_FH, CK_SMP, CK_SH, CK_JDG, CK_REL
    } phase_t;

    // Timing registers
    typedef struct packed {
        logic [TICK_W-1:0] out_half_period;
        logic [TICK_W-1:0] ser_setup;
        logic [TICK_W-1:0] in_half_period;
        logic [TICK_W-1:0] rom_setup;
        logic [TICK_W-1:0] settle_time;
    } timing_t;

    localparam timing_t TIMING_RESET = '{
        out_half_period: 8'd1, ser_setup: 8'd1, in_half_period: 8'd1,
        rom_setup: 8'd1, settle_time: 8'd1
    };

    // Pin levels
    typedef struct packed {
        logic ser;
        logic shift_clk;
        logic latch_clk;
        logic addr_out_disable;
        logic addr_clear_n;
        logic rom_ce_n;
        logic rom_oe_n;
        logic in_shift_mode;
        logic in_clk;
        logic in_clear_n;
    } pins_t;

    localparam pins_t PINS_RESET = '{
        ser: 1'b0, shift_clk: 1'b0, latch_clk: 1'b0, addr_out_disable: 1'b1,
        addr_clear_n: 1'b1, rom_ce_n: 1'b1, rom_oe_n: 1'b1, in_shift_mode: 1'b0,
        in_clk: 1'b0, in_clear_n: 1'b1
    };

    // One result transaction
    typedef struct packed {
        pins_t               pins;
        logic [BYTE_W-1:0]   data_byte;
        logic [STATUS_W-1:0] status;
    } result_t;

    function automatic logic phase_busy(input phase_t ph);
        return (ph >= RD_SER);
    endfunction

    function automatic logic [STATUS_W-1:0] phase_status(input phase_t ph);
        logic [STATUS_W-1:0] st;
        case (ph)
            PH_IDLE:  st = ST_IDLE;
            PH_RDONE: st = ST_READ_DONE;
            PH_PASS:  st = ST_PASS;
            PH_FAIL:  st = ST_FAIL;
            default:  st = ST_BUSY;
        endcase
        return st;
    endfunction

endpackage

FILE: rtl/core/srr_ifs.sv
// ----------------------------------------------------------------------------
// srr_ifs
// Channel interfaces: tick input, result output and configuration write.
// ----------------------------------------------------------------------------
interface srr_in_if;
    import srr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [ADDR_FIELD_W-1:0] address;
    logic                    serial_in;

    modport source (output valid, kind, address, serial_in, input ready);
    modport sink   (input valid, kind, address, serial_in, output ready);
endinterface

interface srr_out_if;
    import srr_pkg::*;
    logic                valid;
    logic                ready;
    logic                ser;
    logic                shift_clk;
    logic                latch_clk;
    logic                addr_out_disable;
    logic                addr_clear_n;
    logic                rom_ce_n;
    logic                rom_oe_n;
    logic                in_shift_mode;
    logic                in_clk;
    logic                in_clear_n;
    logic [BYTE_W-1:0]   data_byte;
    logic [STATUS_W-1:0] status;

    modport source (output valid, ser, shift_clk, latch_clk, addr_out_disable,
                    addr_clear_n, rom_ce_n, rom_oe_n, in_shift_mode, in_clk,
                    in_clear_n, data_byte, status, input ready);
    modport sink   (input valid, ser, shift_clk, latch_clk, addr_out_disable,
                    addr_clear_n, rom_ce_n, rom_oe_n, in_shift_mode, in_clk,
                    in_clear_n, data_byte, status, output ready);
endinterface

interface srr_cfg_if;
    import srr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/srr_cfg.sv
// ----------------------------------------------------------------------------
// srr_cfg
// Timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module srr_cfg (
    input  logic            clk,
    input  logic            rst_n,
    srr_cfg_if.sink         cfg,
    output srr_pkg::timing_t timing
);
    import srr_pkg::*;

    timing_t timing_reg;
    timing_t timing_next;

    // Always take configuration writes
    assign cfg.ready = 1'b1;

    // Decode the register index; unknown indexes are dropped
    always_comb
    begin
        timing_next = timing_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_OUT_HALF_PERIOD: timing_next.out_half_period = cfg.data;
                CFG_SER_SETUP:       timing_next.ser_setup       = cfg.data;
                CFG_IN_HALF_PERIOD:  timing_next.in_half_period  = cfg.data;
                CFG_ROM_SETUP:       timing_next.rom_setup       = cfg.data;
                CFG_SETTLE_TIME:     timing_next.settle_time     = cfg.data;
                default:             timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg <= TIMING_RESET;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    assign timing = timing_reg;

endmodule

FILE: rtl/core/srr_seq.sv
// ----------------------------------------------------------------------------
// srr_seq
// Pin sequencer: one tick per accepted transaction, state held in registers.
// ----------------------------------------------------------------------------
module srr_seq #(
    parameter int ADDR_BITS = srr_pkg::SRR_ADDR_BITS,
    parameter int DATA_BITS = srr_pkg::SRR_DATA_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic [srr_pkg::KIND_W-1:0]        kind,
    input  logic [srr_pkg::ADDR_FIELD_W-1:0]  address,
    input  logic                              serial_in,
    input  srr_pkg::timing_t                  timing,
    output srr_pkg::result_t                  result
);
    import srr_pkg::*;

    localparam int MAX_BITS = (ADDR_BITS > DATA_BITS) ? ADDR_BITS : DATA_BITS;
    localparam int BIT_W    = $clog2(MAX_BITS + 1);
    localparam int AW_WIDE  = (ADDR_BITS > ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;
    localparam logic [BIT_W-1:0] ADDR_LAST = BIT_W'(ADDR_BITS);
    localparam logic [BIT_W-1:0] DATA_LAST = BIT_W'(DATA_BITS);

    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    pins_t                pins_reg, pins_next;

    logic [AW_WIDE-1:0]   addr_wide;
    logic [ADDR_BITS-1:0] addr_load;
    logic [BIT_W-1:0]     bit_inc;
    logic                 busy;

    // Fit the address field to the chain length
    assign addr_wide = AW_WIDE'(address);
    assign addr_load = addr_wide[ADDR_BITS-1:0];

    // Start a read or check if idle, then count down or take one step
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        pins_next  = pins_reg;
        busy       = phase_busy(phase_reg);

        if (!busy && (kind == KIND_READ || kind == KIND_CHECK))
        begin
            tick_next = '0;
            bit_next  = '0;
            busy      = 1'b1;
            if (kind == KIND_READ)
            begin
                addr_next  = addr_load;
                phase_next = RD_SER;
            end
            else
            begin
                phase_next = CK_ACLR;
            end
        end

        bit_inc = bit_next + 1'b1;

        if (busy)
        begin
            if (tick_next != '0)
            begin
                tick_next = tick_next - 1'b1;
            end
            else
            begin
                case (phase_next)
                    RD_SER:
                    begin
                        pins_next.ser = addr_next[ADDR_BITS-1];
                        tick_next     = timing.ser_setup;
                        phase_next    = RD_CKH;
                    end
                    RD_CKH:
                    begin
                        pins_next.shift_clk = 1'b1;
                        tick_next           = timing.out_half_period;
                        phase_next          = RD_CKL;
                    end
                    RD_CKL:
                    begin
                        pins_next.shift_clk = 1'b0;
                        tick_next           = timing.out_half_period;
                        bit_next            = bit_inc;
                        addr_next           = addr_next << 1;
                        phase_next          = (bit_inc < ADDR_LAST) ? RD_SER : RD_LTH;
                    end
                    RD_LTH:
                    begin
                        pins_next.latch_clk = 1'b1;
                        tick_next           = timing.out_half_period;
                        phase_next          = RD_LTL;
                    end
                    RD_LTL:
                    begin
                        pins_next.latch_clk = 1'b0;
                        tick_next           = timing.out_half_period;
                        phase_next          = RD_EN;
                    end
                    RD_EN:
                    begin
                        pins_next.addr_out_disable = 1'b0;
                        pins_next.rom_ce_n         = 1'b0;
                        pins_next.rom_oe_n         = 1'b0;
                        tick_next                  = timing.rom_setup;
                        phase_next                 = RD_LDH;
                    end
                    RD_LDH:
                    begin
                        pins_next.in_clk = 1'b1;
                        tick_next        = timing.in_half_period;
                        phase_next       = RD_LDL;
                    end
                    RD_LDL:
                    begin
                        pins_next.in_clk = 1'b0;
                        tick_next        = timing.in_half_period;
                        phase_next       = RD_MODE;
                    end
                    RD_MODE:
                    begin
                        pins_next.in_shift_mode = 1'b1;
                        tick_next               = timing.settle_time;
                        bit_next                = '0;
                        phase_next              = RD_SMP;
                    end
                    RD_SMP:
                    begin
                        data_next        = {data_next[DATA_BITS-2:0], serial_in};
                        pins_next.in_clk = 1'b1;
                        tick_next        = timing.in_half_period;
                        phase_next       = RD_SCL;
                    end
                    RD_SCL:
                    begin
                        pins_next.in_clk = 1'b0;
                        tick_next        = timing.in_half_period;
                        bit_next         = bit_inc;
                        phase_next       = (bit_inc < DATA_LAST) ? RD_SMP : RD_DIS;
                    end
                    RD_DIS:
                    begin
                        pins_next.addr_out_disable = 1'b1;
                        pins_next.rom_ce_n         = 1'b1;
                        pins_next.rom_oe_n         = 1'b1;
                        pins_next.in_shift_mode    = 1'b0;
                        tick_next                  = timing.settle_time;
                        phase_next                 = RD_END;
                    end
                    RD_END:
                    begin
                        phase_next = PH_RDONE;
                    end
                    CK_ACLR:
                    begin
                        pins_next.addr_out_disable = 1'b1;
                        pins_next.addr_clear_n     = 1'b0;
                        pins_next.shift_clk        = 1'b0;
                        pins_next.latch_clk        = 1'b0;
                        tick_next                  = timing.settle_time;
                        phase_next                 = CK_AREL;
                    end
                    CK_AREL:
                    begin
                        pins_next.addr_clear_n  = 1'b1;
                        pins_next.rom_ce_n      = 1'b1;
                        pins_next.rom_oe_n      = 1'b1;
                        pins_next.in_clk        = 1'b0;
                        pins_next.in_shift_mode = 1'b1;
                        pins_next.in_clear_n    = 1'b0;
                        tick_next               = timing.settle_time;
                        phase_next              = CK_IREL;
                    end
                    CK_IREL:
                    begin
                        pins_next.in_clear_n = 1'b1;
                        tick_next            = timing.in_half_period;
                        bit_next             = '0;
                        phase_next           = CK_FL;
                    end
                    CK_FL:
                    begin
                        pins_next.in_clk = 1'b0;
                        tick_next        = timing.in_half_period;
                        phase_next       = CK_FH;
                    end
                    CK_FH:
                    begin
                        pins_next.in_clk = 1'b1;
                        tick_next        = timing.in_half_period;
                        if (bit_inc < DATA_LAST)
                        begin
                            bit_next   = bit_inc;
                            phase_next = CK_FL;
                        end
                        else
                        begin
                            bit_next   = '0;
                            phase_next = CK_SMP;
                        end
                    end
                    CK_SMP:
                    begin
                        data_next        = {data_next[DATA_BITS-2:0], serial_in};
                        pins_next.in_clk = 1'b0;
                        tick_next        = timing.in_half_period;
                        phase_next       = CK_SH;
                    end
                    CK_SH:
                    begin
                        pins_next.in_clk = 1'b1;
                        tick_next        = timing.in_half_period;
                        bit_next         = bit_inc;
                        phase_next       = (bit_inc < DATA_LAST) ? CK_SMP : CK_JDG;
                    end
                    CK_JDG:
                    begin
                        // Mixed bits fail and leave every pin as it is
                        if (data_next != '0 && data_next != '1)
                        begin
                            phase_next = PH_FAIL;
                        end
                        else
                        begin
                            pins_next.in_clk        = 1'b0;
                            pins_next.in_clear_n    = 1'b0;
                            pins_next.in_shift_mode = 1'b0;
                            tick_next               = timing.settle_time;
                            phase_next              = CK_REL;
                        end
                    end
                    CK_REL:
                    begin
                        pins_next.in_clear_n = 1'b1;
                        phase_next           = PH_PASS;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Advance the state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            addr_reg  <= '0;
            data_reg  <= '0;
            pins_reg  <= PINS_RESET;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            pins_reg  <= pins_next;
        end
    end

    // Build the result of this tick
    always_comb
    begin
        result.pins      = pins_next;
        result.data_byte = (phase_next == PH_RDONE) ? data_next[BYTE_W-1:0] : '0;
        result.status    = phase_status(phase_next);
    end

endmodule

FILE: rtl/core/srr_out_reg.sv
// ----------------------------------------------------------------------------
// srr_out_reg
// Result register; holds a transaction until the sink takes it.
// ----------------------------------------------------------------------------
module srr_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  srr_pkg::result_t result,
    output logic             can_load,
    srr_out_if.source        out_ch
);
    import srr_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Free when empty or being drained this cycle
    assign can_load = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_ch.valid            = valid_reg;
    assign out_ch.ser              = data_reg.pins.ser;
    assign out_ch.shift_clk        = data_reg.pins.shift_clk;
    assign out_ch.latch_clk        = data_reg.pins.latch_clk;
    assign out_ch.addr_out_disable = data_reg.pins.addr_out_disable;
    assign out_ch.addr_clear_n     = data_reg.pins.addr_clear_n;
    assign out_ch.rom_ce_n         = data_reg.pins.rom_ce_n;
    assign out_ch.rom_oe_n         = data_reg.pins.rom_oe_n;
    assign out_ch.in_shift_mode    = data_reg.pins.in_shift_mode;
    assign out_ch.in_clk           = data_reg.pins.in_clk;
    assign out_ch.in_clear_n       = data_reg.pins.in_clear_n;
    assign out_ch.data_byte        = data_reg.data_byte;
    assign out_ch.status           = data_reg.status;

endmodule

FILE: rtl/core/shift_register_rom_reader_top.sv
// ----------------------------------------------------------------------------
// shift_register_rom_reader_top
// Tick-level pin sequencer for a serial-address, serial-data parallel ROM.
// ----------------------------------------------------------------------------
//  channel   direction  payload                               handshake
//  in_ch     sink       kind, address, serial_in              valid/ready
//  out_ch    source     ten pin levels, data_byte, status     valid/ready
//  cfg       sink       index, data (timing registers)        valid/ready
//
//  One tick per clock while in_ch is ready; its result is registered and
//  reaches out_ch in the cycle after acceptance. The sequencer step is the only
//  logic between the state registers and the result register.
//  in_ch is ready whenever the result register is empty or being drained.
//  cfg is always ready. Reset puts the sequencer's pins in their safe level, idle status.
// ----------------------------------------------------------------------------
module shift_register_rom_reader_top #(
    parameter int ADDR_BITS = srr_pkg::SRR_ADDR_BITS,
    parameter int DATA_BITS = srr_pkg::SRR_DATA_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    srr_in_if.sink    in_ch,
    srr_out_if.source out_ch,
    srr_cfg_if.sink   cfg
);
    import srr_pkg::*;

    timing_t timing;
    result_t result;
    logic    can_load;
    logic    in_fire;

    assign in_ch.ready = can_load;
    assign in_fire     = in_ch.valid && can_load;

    // Timing registers
    srr_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .timing (timing)
    );

    // Sequencer
    srr_seq #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .kind      (in_ch.kind),
        .address   (in_ch.address),
        .serial_in (in_ch.serial_in),
        .timing    (timing),
        .result    (result)
    );

    // Result register
    srr_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire),
        .result   (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

FILE: rtl/core/srr_checker.sv
// ----------------------------------------------------------------------------
// srr_checker
// Port-level checks of the ROM reader, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [9:0]                     out_pins,
    input logic [srr_pkg::BYTE_W-1:0]     data_byte,
    input logic [srr_pkg::STATUS_W-1:0]   status
);
    import srr_pkg::*;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // An empty result register must never stall the input
    `ASSERT_IMPLIES(a_ready_when_empty, !out_valid, in_ready, "input stalled while output empty")

    // Every accepted tick yields a result in the next cycle
    `ASSERT_NEXT(a_result_follows, in_fire, out_valid, "no result after accepted tick")

    // The data byte is zero unless a read has just finished
    `ASSERT_IMPLIES(a_byte_only_done, out_valid && status != ST_READ_DONE, data_byte == '0,
                    "data byte set outside read done")

    // A stalled result holds its payload
    `ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready,
                 out_valid && $stable(out_pins) && $stable(data_byte) && $stable(status),
                 "stalled result changed")

endmodule

bind shift_register_rom_reader_top srr_checker u_srr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pins  ({out_ch.ser, out_ch.shift_clk, out_ch.latch_clk, out_ch.addr_out_disable,
                 out_ch.addr_clear_n, out_ch.rom_ce_n, out_ch.rom_oe_n,
                 out_ch.in_shift_mode, out_ch.in_clk, out_ch.in_clear_n}),
    .data_byte (out_ch.data_byte),
    .status    (out_ch.status)
);

FILE: tb/rom_reader_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_reader_checker
// Watches the tick, result and timing register channels of the ROM reader.
// Keeps its own copy of the pin sequencer and compares every result
// transaction with the predicted pin levels, data byte and status.
// ----------------------------------------------------------------------------
module rom_reader_checker (
    input  logic clk,
    input  logic rst_n,
    srr_in_if    tick_ch,
    srr_out_if   pin_ch,
    srr_cfg_if   cfg_ch,
    output int   mismatch_count,
    output int   pending_count,
    output logic seq_busy,
    output int   reads_done,
    output int   checks_passed,
    output int   checks_failed
);
    import srr_pkg::*;

    // Predicted sequencer state and timing registers
    timing_t                  timing;
    phase_t                   phase;
    logic [TICK_W-1:0]        wait_ticks;
    logic [4:0]               bit_pos;
    logic [SRR_ADDR_BITS-1:0] addr_bits;
    logic [SRR_DATA_BITS-1:0] sampled_bits;
    pins_t                    pins;

    // Expected pin snapshots, oldest first
    result_t pin_snapshots_q[$];

    // Perform one sequencer step: pin changes plus the wait of that step
    task automatic step_sequencer(input logic line);
        case (phase)
            RD_SER: begin
                pins.ser   = addr_bits[SRR_ADDR_BITS - 1 - bit_pos];
                wait_ticks = timing.ser_setup;
                phase      = RD_CKH;
            end
            RD_CKH: begin
                pins.shift_clk = 1'b1;
                wait_ticks     = timing.out_half_period;
                phase          = RD_CKL;
            end
            RD_CKL: begin
                pins.shift_clk = 1'b0;
                wait_ticks     = timing.out_half_period;
                bit_pos++;
                phase = (bit_pos < SRR_ADDR_BITS) ? RD_SER : RD_LTH;
            end
            RD_LTH: begin
                pins.latch_clk = 1'b1;
                wait_ticks     = timing.out_half_period;
                phase          = RD_LTL;
            end
            RD_LTL: begin
                pins.latch_clk = 1'b0;
                wait_ticks     = timing.out_half_period;
                phase          = RD_EN;
            end
            RD_EN: begin
                pins.addr_out_disable = 1'b0;
                pins.rom_ce_n         = 1'b0;
                pins.rom_oe_n         = 1'b0;
                wait_ticks            = timing.rom_setup;
                phase                 = RD_LDH;
            end
            RD_LDH: begin
                pins.in_clk = 1'b1;
                wait_ticks  = timing.in_half_period;
                phase       = RD_LDL;
            end
            RD_LDL: begin
                pins.in_clk = 1'b0;
                wait_ticks  = timing.in_half_period;
                phase       = RD_MODE;
            end
            RD_MODE: begin
                pins.in_shift_mode = 1'b1;
                wait_ticks         = timing.settle_time;
                bit_pos            = '0;
                phase              = RD_SMP;
            end
            RD_SMP: begin
                sampled_bits = {sampled_bits[SRR_DATA_BITS-2:0], line};
                pins.in_clk  = 1'b1;
                wait_ticks   = timing.in_half_period;
                phase        = RD_SCL;
            end
            RD_SCL: begin
                pins.in_clk = 1'b0;
                wait_ticks  = timing.in_half_period;
                bit_pos++;
                phase = (bit_pos < SRR_DATA_BITS) ? RD_SMP : RD_DIS;
            end
            RD_DIS: begin
                pins.addr_out_disable = 1'b1;
                pins.rom_ce_n         = 1'b1;
                pins.rom_oe_n         = 1'b1;
                pins.in_shift_mode    = 1'b0;
                wait_ticks            = timing.settle_time;
                phase                 = RD_END;
            end
            RD_END: phase = PH_RDONE;
            CK_ACLR: begin
                pins.addr_out_disable = 1'b1;
                pins.addr_clear_n     = 1'b0;
                pins.shift_clk        = 1'b0;
                pins.latch_clk        = 1'b0;
                wait_ticks            = timing.settle_time;
                phase                 = CK_AREL;
            end
            CK_AREL: begin
                pins.addr_clear_n  = 1'b1;
                pins.rom_ce_n      = 1'b1;
                pins.rom_oe_n      = 1'b1;
                pins.in_clk        = 1'b0;
                pins.in_shift_mode = 1'b1;
                pins.in_clear_n    = 1'b0;
                wait_ticks         = timing.settle_time;
                phase              = CK_IREL;
            end
            CK_IREL: begin
                pins.in_clear_n = 1'b1;
                wait_ticks      = timing.in_half_period;
                bit_pos         = '0;
                phase           = CK_FL;
            end
            CK_FL: begin
                pins.in_clk = 1'b0;
                wait_ticks  = timing.in_half_period;
                phase       = CK_FH;
            end
            CK_FH: begin
                pins.in_clk = 1'b1;
                wait_ticks  = timing.in_half_period;
                bit_pos++;
                if (bit_pos < SRR_DATA_BITS) begin
                    phase = CK_FL;
                end
                else begin
                    bit_pos = '0;
                    phase   = CK_SMP;
                end
            end
            CK_SMP: begin
                sampled_bits = {sampled_bits[SRR_DATA_BITS-2:0], line};
                pins.in_clk  = 1'b0;
                wait_ticks   = timing.in_half_period;
                phase        = CK_SH;
            end
            CK_SH: begin
                pins.in_clk = 1'b1;
                wait_ticks  = timing.in_half_period;
                bit_pos++;
                phase = (bit_pos < SRR_DATA_BITS) ? CK_SMP : CK_JDG;
            end
            CK_JDG: begin
                // Stop on a mixed pattern and leave every pin where it is
                if (sampled_bits != '0 && sampled_bits != '1) begin
                    phase = PH_FAIL;
                end
                else begin
                    pins.in_clk        = 1'b0;
                    pins.in_clear_n    = 1'b0;
                    pins.in_shift_mode = 1'b0;
                    wait_ticks         = timing.settle_time;
                    phase              = CK_REL;
                end
            end
            CK_REL: begin
                pins.in_clear_n = 1'b1;
                phase           = PH_PASS;
            end
            default: phase = PH_IDLE;
        endcase
    endtask

    // Advance the sequencer by one tick transaction and form its result
    task automatic predict_tick(input logic [KIND_W-1:0] kind,
                                input logic [ADDR_FIELD_W-1:0] addr,
                                input logic line, output result_t res);
        // Starts are honored only while no operation runs
        if (phase < RD_SER && (kind == KIND_READ || kind == KIND_CHECK)) begin
            wait_ticks = '0;
            bit_pos    = '0;
            if (kind == KIND_READ) begin
                addr_bits = addr[SRR_ADDR_BITS-1:0];
                phase     = RD_SER;
            end
            else begin
                phase = CK_ACLR;
            end
        end
        if (phase >= RD_SER) begin
            if (wait_ticks != '0)
                wait_ticks--;
            else
                step_sequencer(line);
            case (phase)
                PH_RDONE: reads_done++;
                PH_PASS:  checks_passed++;
                PH_FAIL:  checks_failed++;
                default:  ;
            endcase
        end
        res.pins      = pins;
        res.data_byte = (phase == PH_RDONE) ? sampled_bits[BYTE_W-1:0] : '0;
        case (phase)
            PH_IDLE:  res.status = ST_IDLE;
            PH_RDONE: res.status = ST_READ_DONE;
            PH_PASS:  res.status = ST_PASS;
            PH_FAIL:  res.status = ST_FAIL;
            default:  res.status = ST_BUSY;
        endcase
    endtask

    // Compare one result transaction with its expectation, field by field
    task automatic compare_result(input result_t want, input result_t got);
        if (got.pins !== want.pins || got.data_byte !== want.data_byte ||
            got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("[%0t] result mismatch", $time);
                if (got.pins !== want.pins)
                    $display("  pins ser,sclk,lclk,aod,aclr_n,ce_n,oe_n,mode,iclk,iclr_n: %s %b got %b",
                             "expected", want.pins, got.pins);
                if (got.data_byte !== want.data_byte)
                    $display("  data_byte: expected %02h got %02h",
                             want.data_byte, got.data_byte);
                if (got.status !== want.status)
                    $display("  status: expected %0d got %0d", want.status, got.status);
            end
        end
    endtask

    // Track every handshake on the three channels
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t got;
        if (!rst_n) begin
            timing         = TIMING_RESET;
            phase          = PH_IDLE;
            wait_ticks     = '0;
            bit_pos        = '0;
            addr_bits      = '0;
            sampled_bits   = '0;
            pins           = PINS_RESET;
            pin_snapshots_q.delete();
            mismatch_count = 0;
            reads_done     = 0;
            checks_passed  = 0;
            checks_failed  = 0;
            pending_count  <= 0;
            seq_busy       <= 1'b0;
        end
        else begin
            // Retire the oldest expectation against the result transaction
            if (pin_ch.valid && pin_ch.ready) begin
                got.pins.ser              = pin_ch.ser;
                got.pins.shift_clk        = pin_ch.shift_clk;
                got.pins.latch_clk        = pin_ch.latch_clk;
                got.pins.addr_out_disable = pin_ch.addr_out_disable;
                got.pins.addr_clear_n     = pin_ch.addr_clear_n;
                got.pins.rom_ce_n         = pin_ch.rom_ce_n;
                got.pins.rom_oe_n         = pin_ch.rom_oe_n;
                got.pins.in_shift_mode    = pin_ch.in_shift_mode;
                got.pins.in_clk           = pin_ch.in_clk;
                got.pins.in_clear_n       = pin_ch.in_clear_n;
                got.data_byte             = pin_ch.data_byte;
                got.status                = pin_ch.status;
                if (pin_snapshots_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result transaction with nothing pending, status %0d",
                                 $time, got.status);
                end
                else begin
                    want = pin_snapshots_q.pop_front();
                    compare_result(want, got);
                end
            end

            // Apply timing register writes
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_OUT_HALF_PERIOD: timing.out_half_period = cfg_ch.data;
                    CFG_SER_SETUP:       timing.ser_setup       = cfg_ch.data;
                    CFG_IN_HALF_PERIOD:  timing.in_half_period  = cfg_ch.data;
                    CFG_ROM_SETUP:       timing.rom_setup       = cfg_ch.data;
                    CFG_SETTLE_TIME:     timing.settle_time     = cfg_ch.data;
                    default:             ;
                endcase
            end

            // Predict the result of each accepted tick transaction
            if (tick_ch.valid && tick_ch.ready) begin
                predict_tick(tick_ch.kind, tick_ch.address, tick_ch.serial_in, want);
                pin_snapshots_q.push_back(want);
            end

            pending_count <= pin_snapshots_q.size();
            seq_busy      <= (phase >= RD_SER);
        end
    end

endmodule

FILE: tb/shift_register_rom_reader_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_register_rom_reader_top_tb
// Drives byte reads, reset checks and plain ticks into the ROM reader under
// two timing register settings and four idling patterns; a checker beside the
// block predicts every result transaction and counts mismatches.
// ----------------------------------------------------------------------------
module shift_register_rom_reader_top_tb;
    import srr_pkg::*;

    localparam int                CYCLE_LIMIT  = 20000;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    // Every operation takes more steps than this, so early starts land while busy
    localparam int                NOISE_WINDOW = 32;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    srr_in_if  tick_ch ();
    srr_out_if pin_ch ();
    srr_cfg_if cfg_ch ();

    int   mismatch_count;
    int   pending_count;
    logic seq_busy;
    int   reads_done;
    int   checks_passed;
    int   checks_failed;

    int gap_pct        = 0;
    int stall_pct      = 0;
    int items_sent     = 0;
    int ops_started    = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    shift_register_rom_reader_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (tick_ch),
        .out_ch (pin_ch),
        .cfg    (cfg_ch)
    );

    rom_reader_checker sequencer_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_ch        (tick_ch),
        .pin_ch         (pin_ch),
        .cfg_ch         (cfg_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .seq_busy       (seq_busy),
        .reads_done     (reads_done),
        .checks_passed  (checks_passed),
        .checks_failed  (checks_failed)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pin_ch.ready <= 1'b1;
        else
            pin_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Select gap and stall rates for the next operation
    task automatic pick_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                gap_pct   = 0;
                stall_pct <= 0;
            end
            IDLE_SENDER:
            begin
                gap_pct   = 54;
                stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                gap_pct   = 0;
                stall_pct <= 54;
            end
            default:
            begin
                gap_pct   = 12;
                stall_pct <= 12;
            end
        endcase
    endtask

    // Send one tick transaction; valid stays high for a following one
    task automatic send_tick(input logic [KIND_W-1:0] kind,
                             input logic [ADDR_FIELD_W-1:0] addr, input logic line);
        while ($urandom_range(99) < gap_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.kind      <= kind;
        tick_ch.address   <= addr;
        tick_ch.serial_in <= line;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Start one operation and tick until the sequencer is done with it
    task automatic run_op(input logic [KIND_W-1:0] kind,
                          input logic [ADDR_FIELD_W-1:0] addr,
                          input bit hold_line, input logic line, input int noise_pct);
        logic [KIND_W-1:0] k;
        int                n;
        pick_idling(idle_mode_t'(ops_started % 4));
        // Idle ticks first, some with an unknown kind
        repeat ($urandom_range(2))
            send_tick($urandom_range(1) ? KIND_TICK : KIND_UNUSED,
                      ADDR_FIELD_W'($urandom), logic'($urandom_range(1)));
        send_tick(kind, addr, hold_line ? line : logic'($urandom_range(1)));
        ops_started++;
        n = 0;
        do
        begin
            k = KIND_TICK;
            // Inject starts that land while busy
            if (n < NOISE_WINDOW && $urandom_range(99) < noise_pct)
            begin
                case ($urandom_range(2))
                    0:       k = KIND_READ;
                    1:       k = KIND_CHECK;
                    default: k = KIND_UNUSED;
                endcase
            end
            send_tick(k, ADDR_FIELD_W'($urandom),
                      hold_line ? line : logic'($urandom_range(1)));
            n++;
        end
        while (seq_busy);
    endtask

    // Hold off until every result has arrived
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_timing(input timing_t t);
        write_reg(CFG_OUT_HALF_PERIOD, t.out_half_period);
        write_reg(CFG_SER_SETUP, t.ser_setup);
        write_reg(CFG_IN_HALF_PERIOD, t.in_half_period);
        write_reg(CFG_ROM_SETUP, t.rom_setup);
        write_reg(CFG_SETTLE_TIME, t.settle_time);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    initial
    begin
        timing_t t;

        rst_n             <= 1'b0;
        tick_ch.valid     <= 1'b0;
        tick_ch.kind      <= KIND_TICK;
        tick_ch.address   <= '0;
        tick_ch.serial_in <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_OUT_HALF_PERIOD;
        cfg_ch.data       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: a read, a check on random levels, a read from the stopped pins
        settings_used = 1;
        send_tick(KIND_UNUSED, 24'hFFFFFF, 1'b1);
        run_op(KIND_READ, 24'hA5C3F0, 1'b1, 1'b1, 20);
        run_op(KIND_CHECK, ADDR_FIELD_W'($urandom), 1'b0, 1'b0, 0);
        run_op(KIND_READ, 24'h5A5A5A, 1'b0, 1'b0, 0);

        // Short timing: zero setup and settle waits, nonzero half periods
        wait_drained();
        t.out_half_period = 8'd1;
        t.ser_setup       = 8'd0;
        t.in_half_period  = 8'd1;
        t.rom_setup       = 8'd0;
        t.settle_time     = 8'd0;
        load_timing(t);
        run_op(KIND_CHECK, ADDR_FIELD_W'($urandom), 1'b1, 1'b1, 20);
        run_op(KIND_READ, 24'h000000, 1'b1, 1'b0, 0);

        wait_drained();
        repeat (16) @(posedge clk);
        $display("Sent %0d tick transactions in %0d operations over %0d timing settings.",
                 items_sent, ops_started, settings_used);
        $display("Completed %0d byte reads, %0d reset checks passed, %0d failed.",
                 reads_done, checks_passed, checks_failed);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
